FILE: rtl/core/pse_pkg.sv
`default_nettype none

package pse_pkg;

	localparam int DefStackDepth = 16;
	localparam int DefValueBits  = 8;

	localparam logic [7:0] SymZero   = 8'd48;
	localparam logic [7:0] SymPlus   = 8'd43;
	localparam logic [7:0] SymMinus  = 8'd45;
	localparam logic [7:0] SymTimes  = 8'd42;
	localparam logic [7:0] SymDivide = 8'd47;

	typedef enum logic [2:0] {
		StOk        = 3'd0,
		StOverflow  = 3'd1,
		StUnderflow = 3'd2,
		StDivZero   = 3'd3,
		StUnknown   = 3'd4
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/postfix_stack_evaluator_top.sv
`default_nettype none

// Postfix expression evaluator. The input channel (in_valid, in_stall) takes one
// expression character per item on symbol, with end_of_expr marking the last one.
// The output channel (out_valid, out_stall) gives one item on value and status for
// each finished expression or error. Digits push onto an operand stack; the top
// entry lives in a register and the rest in a RAM with one write and one read port.
// A digit or an unknown symbol needs no execute step. An operator reads the
// earlier operand from the RAM as it is taken and then adds, subtracts or
// multiplies in the execute step. Division instead runs a restoring divider that
// forms the quotient bit by bit. An item that gives a result then passes through
// an emit step that hands it to the output register.
// The output register holds a result while out_stall is high; new items are still
// taken then, and only an item with a further result waits for that register.
// Reset empties the stack and ends any discarding of a failed expression; the
// RAM keeps its contents, but no entry is read before it has been written.
module postfix_stack_evaluator_top import pse_pkg::*; #(
	parameter int STACK_DEPTH = DefStackDepth,
	parameter int VALUE_BITS  = DefValueBits
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [7:0]                   symbol,
	input  wire logic                         end_of_expr,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [VALUE_BITS-1:0]      value,
	output logic        [2:0]                 status
);

	localparam int AddrW = $clog2(STACK_DEPTH);
	localparam int CntW  = $clog2(STACK_DEPTH + 1);
	localparam int DivW  = $clog2(VALUE_BITS);

	typedef enum logic [1:0] {
		SIdle,
		SExec,
		SDiv,
		SEmit
	} state_t;

	typedef enum logic [1:0] {
		OpAdd,
		OpSub,
		OpMul,
		OpDiv
	} op_t;

	state_t                  state_q;
	op_t                     op_q;
	logic                    last_q;
	logic                    discard_q;
	logic [CntW-1:0]         count_q;
	logic [VALUE_BITS-1:0]   top_q;
	logic [VALUE_BITS-1:0]   res_value_q;
	status_t                 res_status_q;
	logic                    out_valid_q;
	logic [VALUE_BITS-1:0]   value_q;
	status_t                 status_q;

	logic [VALUE_BITS-1:0]   quo_q;
	logic [VALUE_BITS-1:0]   rem_q;
	logic [VALUE_BITS-1:0]   dvs_q;
	logic                    neg_q;
	logic [DivW-1:0]         div_cnt_q;

	logic                    accept;
	logic                    is_digit;
	logic                    is_op;
	op_t                     op_dec;
	logic [7:0]              dig8;
	logic [31:0]             dig32;
	logic [VALUE_BITS-1:0]   push_val;
	logic [CntW-1:0]         count_m1;
	logic [CntW-1:0]         count_m2;

	logic                    wr_en;
	logic                    rd_en;
	logic [VALUE_BITS-1:0]   rd_data;

	logic [VALUE_BITS:0]     trial;
	logic [VALUE_BITS:0]     diff;
	logic                    ge;
	logic [VALUE_BITS-1:0]   rem_nx;
	logic [VALUE_BITS-1:0]   quo_nx;
	logic [VALUE_BITS-1:0]   div_res;
	logic [2*VALUE_BITS-1:0] prod;
	logic [VALUE_BITS-1:0]   alu_res;
	logic                    finish;
	logic [VALUE_BITS-1:0]   a_mag;
	logic [VALUE_BITS-1:0]   b_mag;
	logic                    out_free;

	assign in_stall = (state_q != SIdle);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		is_op  = 1'b1;
		op_dec = OpAdd;
		case (symbol)
			SymPlus:   op_dec = OpAdd;
			SymMinus:  op_dec = OpSub;
			SymTimes:  op_dec = OpMul;
			SymDivide: op_dec = OpDiv;
			default:   is_op  = 1'b0;
		endcase
	end

	assign is_digit = (symbol >= SymZero);
	assign dig8     = symbol - SymZero;
	assign dig32    = {24'd0, dig8};
	assign push_val = dig32[VALUE_BITS-1:0];
	assign count_m1 = count_q - 1'b1;
	assign count_m2 = count_q - 2'd2;

	assign wr_en = accept && !discard_q && is_digit && (count_q != '0)
		&& (count_q < CntW'(STACK_DEPTH));
	assign rd_en = accept && !discard_q && !is_digit && is_op && (count_q >= CntW'(2));

	pse_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_m1[AddrW-1:0]),
		.wr_data (top_q),
		.rd_en   (rd_en),
		.rd_addr (count_m2[AddrW-1:0]),
		.rd_data (rd_data)
	);

	assign trial   = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff    = trial - {1'b0, dvs_q};
	assign ge      = !diff[VALUE_BITS];
	assign rem_nx  = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
	assign quo_nx  = {quo_q[VALUE_BITS-2:0], ge};
	assign div_res = neg_q ? ('0 - quo_nx) : quo_nx;
	assign prod    = rd_data * top_q;
	assign a_mag   = rd_data[VALUE_BITS-1] ? ('0 - rd_data) : rd_data;
	assign b_mag   = top_q[VALUE_BITS-1] ? ('0 - top_q) : top_q;

	always_comb begin
		case (op_q)
			OpAdd:   alu_res = rd_data + top_q;
			OpSub:   alu_res = rd_data - top_q;
			OpMul:   alu_res = prod[VALUE_BITS-1:0];
			default: alu_res = div_res;
		endcase
	end

	assign finish = ((state_q == SExec) && (op_q != OpDiv))
		|| ((state_q == SDiv) && (div_cnt_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SIdle;
			op_q         <= OpAdd;
			last_q       <= 1'b0;
			discard_q    <= 1'b0;
			count_q      <= '0;
			top_q        <= '0;
			res_value_q  <= '0;
			out_valid_q  <= 1'b0;
			value_q      <= '0;
			res_status_q <= StOk;
			status_q     <= StOk;
			quo_q        <= '0;
			rem_q        <= '0;
			dvs_q        <= '0;
			neg_q        <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != SEmit)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				SIdle: begin
					if (accept) begin
						last_q <= end_of_expr;
						op_q   <= op_dec;
						if (discard_q) begin
							if (end_of_expr) begin
								discard_q <= 1'b0;
							end
						end else if (is_digit) begin
							if (count_q >= CntW'(STACK_DEPTH)) begin
								res_value_q  <= '0;
								res_status_q <= StOverflow;
								count_q      <= '0;
								discard_q    <= !end_of_expr;
								state_q      <= SEmit;
							end else if (end_of_expr) begin
								res_value_q  <= push_val;
								res_status_q <= StOk;
								count_q      <= '0;
								state_q      <= SEmit;
							end else begin
								top_q   <= push_val;
								count_q <= count_q + 1'b1;
							end
						end else if (!is_op || (count_q < CntW'(2))) begin
							res_value_q  <= '0;
							res_status_q <= is_op ? StUnderflow : StUnknown;
							count_q      <= '0;
							discard_q    <= !end_of_expr;
							state_q      <= SEmit;
						end else begin
							state_q <= SExec;
						end
					end
				end
				SExec: begin
					if (op_q == OpDiv) begin
						if (top_q == '0) begin
							res_value_q  <= '0;
							res_status_q <= StDivZero;
							count_q      <= '0;
							discard_q    <= !last_q;
							state_q      <= SEmit;
						end else begin
							quo_q     <= a_mag;
							rem_q     <= '0;
							dvs_q     <= b_mag;
							neg_q     <= rd_data[VALUE_BITS-1] ^ top_q[VALUE_BITS-1];
							div_cnt_q <= DivW'(VALUE_BITS - 1);
							state_q   <= SDiv;
						end
					end
				end
				SDiv: begin
					quo_q     <= quo_nx;
					rem_q     <= rem_nx;
					div_cnt_q <= div_cnt_q - 1'b1;
				end
				SEmit: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						value_q     <= res_value_q;
						status_q    <= res_status_q;
						state_q     <= SIdle;
					end
				end
				default: begin
					state_q <= SIdle;
				end
			endcase
			if (finish) begin
				top_q <= alu_res;
				if (last_q) begin
					res_value_q  <= alu_res;
					res_status_q <= StOk;
					count_q      <= '0;
					state_q      <= SEmit;
				end else begin
					count_q <= count_m1;
					state_q <= SIdle;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(STACK_DEPTH))
		else $error("operand count beyond stack depth");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == SEmit))
		else $error("result loaded outside the emit step");

	a_discard_idle: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> (state_q == SIdle || state_q == SEmit))
		else $error("arithmetic running while an expression is discarded");

endmodule

`default_nettype wire

FILE: rtl/core/pse_ram.sv
`default_nettype none

module pse_ram import pse_pkg::*; #(
	parameter int WIDTH = DefValueBits,
	parameter int DEPTH = DefStackDepth
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: test/postfix_stack_evaluator_top_tb.sv
module postfix_stack_evaluator_top_tb;
	import pse_pkg::*;

	localparam int Depth = DefStackDepth;
	localparam int Bits = DefValueBits;
	localparam int CycleLimit = 500000;

	typedef struct packed {
		logic signed [Bits-1:0] val;
		status_t                stat;
	} outcome_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             symbol = 8'd0;
	logic                   end_of_expr = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [Bits-1:0] value;
	logic [2:0]             status;

	logic signed [Bits-1:0] operands [Depth];
	int                     held = 0;
	bit                     skipping = 1'b0;
	outcome_t               pending_results [$];
	outcome_t               want;
	int                     fed_items = 0;
	int                     mismatches = 0;
	int                     cycle = 0;
	int                     snd_pct = 0;
	int                     rcv_pct = 0;
	int                     hold_left = 0;

	postfix_stack_evaluator_top #(
		.STACK_DEPTH(Depth),
		.VALUE_BITS(Bits)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.symbol(symbol),
		.end_of_expr(end_of_expr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.status(status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Works out what one accepted item does to the operand stack and which result it gives.
	function automatic void eval_symbol(logic [7:0] sym, logic last);
		status_t                st;
		logic signed [Bits-1:0] earlier;
		logic signed [Bits-1:0] later;
		logic signed [Bits-1:0] res;
		int                     quot;
		outcome_t               item;
		st = StOk;
		res = '0;
		fed_items++;
		if (skipping) begin
			if (last)
				skipping = 1'b0;
			return;
		end
		if (sym >= SymZero) begin
			if (held >= Depth)
				st = StOverflow;
			else begin
				operands[held] = sym - SymZero;
				held++;
			end
		end else if (sym != SymPlus && sym != SymMinus && sym != SymTimes && sym != SymDivide) begin
			st = StUnknown;
		end else if (held < 2) begin
			st = StUnderflow;
		end else begin
			later = operands[held-1];
			earlier = operands[held-2];
			case (sym)
				SymPlus: res = earlier + later;
				SymMinus: res = earlier - later;
				SymTimes: res = earlier * later;
				default: begin
					if (later == 0)
						st = StDivZero;
					else begin
						quot = int'(earlier) / int'(later);
						res = quot[Bits-1:0];
					end
				end
			endcase
			if (st == StOk) begin
				held--;
				operands[held-1] = res;
			end
		end
		if (st != StOk) begin
			held = 0;
			if (!last)
				skipping = 1'b1;
			item.val = '0;
			item.stat = st;
			pending_results.push_back(item);
		end else if (last) begin
			item.val = (held == 0) ? '0 : operands[held-1];
			item.stat = (held == 0) ? StUnderflow : StOk;
			pending_results.push_back(item);
			held = 0;
		end
	endfunction

	always @(posedge clk) begin
		cycle++;
		if (cycle > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else
			out_stall <= ($urandom_range(99) < rcv_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: value %0d status %0d", value, status);
			end else begin
				want = pending_results.pop_front();
				if (value !== want.val || status !== want.stat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected value %0d status %0d, got value %0d status %0d",
							want.val, want.stat, value, status);
				end
			end
		end
	end

	task automatic send_symbol(logic [7:0] sym, logic last);
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= sym;
		end_of_expr <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		eval_symbol(sym, last);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Builds a random postfix expression whose stack depth stays at or below max_depth.
	task automatic send_expression(int max_depth, int push_pct);
		int         len;
		int         depth;
		int         i;
		logic [7:0] sym;
		len = $urandom_range(2 * max_depth, 1);
		depth = 0;
		for (i = 0; i < len; i++) begin
			if (depth < 2 || (depth < max_depth && $urandom_range(99) < push_pct)) begin
				if ($urandom_range(9) == 0)
					sym = 8'($urandom_range(255, 58));
				else
					sym = 8'($urandom_range(57, 48));
				depth++;
			end else begin
				case ($urandom_range(3))
					0: sym = SymPlus;
					1: sym = SymMinus;
					2: sym = SymTimes;
					default: sym = SymDivide;
				endcase
				depth--;
			end
			send_symbol(sym, i == len - 1);
		end
	endtask

	task automatic test_directed();
		send_symbol(SymZero + 8'd3, 1'b0);
		send_symbol(SymZero + 8'd4, 1'b0);
		send_symbol(SymPlus, 1'b1);
		send_symbol(SymZero + 8'd2, 1'b0);
		send_symbol(SymZero + 8'd9, 1'b0);
		send_symbol(SymMinus, 1'b1);
		send_symbol(SymZero + 8'd9, 1'b0);
		send_symbol(SymZero + 8'd9, 1'b0);
		send_symbol(SymTimes, 1'b1);
		// The most negative value divided by minus one wraps back to itself.
		send_symbol(8'd176, 1'b0);
		send_symbol(SymZero, 1'b0);
		send_symbol(SymZero + 8'd1, 1'b0);
		send_symbol(SymMinus, 1'b0);
		send_symbol(SymDivide, 1'b1);
		send_symbol(SymZero + 8'd5, 1'b0);
		send_symbol(SymZero, 1'b0);
		send_symbol(SymDivide, 1'b0);
		send_symbol(SymZero + 8'd7, 1'b1);
		send_symbol(SymPlus, 1'b1);
		send_symbol(8'd0, 1'b1);
		send_symbol(SymZero + 8'd3, 1'b0);
		send_symbol(8'd255, 1'b1);
		wait_drained();
	endtask

	task automatic test_stack_limits();
		int i;
		for (i = 0; i < Depth; i++)
			send_symbol(SymZero + 8'd9, 1'b0);
		for (i = 1; i < Depth; i++)
			send_symbol((i % 2) ? SymTimes : SymPlus, i == Depth - 1);
		for (i = 0; i <= Depth; i++)
			send_symbol(SymZero + 8'($urandom_range(9)), 1'b0);
		send_symbol(SymPlus, 1'b0);
		send_symbol(SymZero + 8'd1, 1'b1);
		send_symbol(SymZero + 8'd6, 1'b1);
		wait_drained();
	endtask

	task automatic test_backpressure();
		int i;
		snd_pct = 0;
		hold_left = 300;
		for (i = 0; i < 24; i++)
			send_symbol(SymZero + 8'($urandom_range(9)), 1'b1);
		wait_drained();
	endtask

	task automatic test_random_phase(int s_pct, int r_pct, int count);
		int stop_at;
		int pick;
		snd_pct = s_pct;
		rcv_pct = r_pct;
		stop_at = fed_items + count;
		while (fed_items < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 80)
				send_expression($urandom_range(5, 2), 50);
			else if (pick < 86)
				send_expression(Depth, 80);
			else if (pick < 88)
				send_expression(Depth + 1, 95);
			else
				send_symbol(8'($urandom_range(255)), $urandom_range(2) == 0);
		end
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		snd_pct = 12;
		rcv_pct = 59;
		test_directed();
		test_stack_limits();
		test_random_phase(12, 59, 435);
		test_backpressure();
		test_random_phase(59, 12, 435);
		test_random_phase(0, 0, 435);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
